>>> design/stg_pkg.sv
// Package for the sine tone generator with fade: field widths, FSM states
// and the quarter-wave sine ROM contents, built at elaboration.
// No dependencies.
`timescale 1ns / 1ps

package stg_pkg;

  localparam int PHASE_BITS = 32;
  localparam int LEN_W      = 24;
  localparam int SINE_DEPTH = 1024;
  localparam int IDX_W      = $clog2(SINE_DEPTH);

  localparam int RATE_W   = 18;
  localparam int FREQ_W   = 19;
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 15;
  localparam int T_W      = LEN_W + 1;

  // step divider: divisor is rate * 16, dividend is frequency * 2^PHASE_BITS
  localparam int DSOR_W = RATE_W + 4;
  localparam int DVD_W  = FREQ_W + PHASE_BITS;

  // fade datapath
  localparam int GAIN20_W = LEN_W + 5;
  localparam int PROD_W   = MAG_W + LEN_W;

  localparam int CNT_W = $clog2(DVD_W + 1);

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);
  localparam logic [MAG_W-1:0]  FULL_SCALE = MAG_W'(32767);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOOKUP,
    ST_PREP,
    ST_MUL,
    ST_FDIV,
    ST_EMIT
  } stg_state_t;

  typedef logic [MAG_W-1:0] sine_rom_t [SINE_DEPTH];

  // round(32767 * sin(pi/2 * k / depth)) by a truncated Q30 Taylor series
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) / SINE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 0; n < 8; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n];
        if ((n % 2) == 0) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      rom[k] = v[MAG_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

>>> design/stg_in_if.sv
// Input channel of the tone generator: one sample tick per request.
// Depends on stg_pkg for the field widths.
`timescale 1ns / 1ps

interface stg_in_if import stg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              start_req;
  logic [FREQ_W-1:0] frequency;
  logic [LEN_W-1:0]  note_length;

  modport source (output valid, start_req, frequency, note_length, input ready);
  modport sink   (input valid, start_req, frequency, note_length, output ready);
endinterface

>>> design/stg_out_if.sv
// Result channel of the tone generator: one sample per request.
// Depends on stg_pkg for the field widths.
`timescale 1ns / 1ps

interface stg_out_if import stg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       playing;

  modport source (output valid, sample, playing, input ready);
  modport sink   (input valid, sample, playing, output ready);
endinterface

>>> design/sine_tone_generator_with_fade.sv
// Sine tone generator with linear fade, top level.
// Depends on stg_pkg, stg_in_if and stg_out_if.
//
// Each input request is one sample tick and gives exactly one output sample.
// Requests are taken one at a time; a finished sample waits in the output
// register, so the next request is taken while it is still pending. A tick
// without fade passes through the table read and prepare steps to the output; a
// tick inside a fade adds a bit-serial multiply of sine by gain, then a restoring
// divide by the note length. A tick with start set first runs the phase-step
// divider, one quotient bit per cycle over the 51-bit dividend (skipped when
// the sample rate is zero). A sample-rate write takes effect at the next start.
`timescale 1ns / 1ps

module sine_tone_generator_with_fade import stg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [RATE_W-1:0] cfg_wdata,
  stg_in_if.sink            in_ch,
  stg_out_if.source         out_ch
);

  stg_state_t state_r, state_nxt;

  logic [RATE_W-1:0]     rate_r;
  logic [PHASE_BITS-1:0] step_r;
  logic [PHASE_BITS-1:0] ph_r;
  logic [T_W-1:0]        t_r;
  logic [LEN_W-1:0]      len_r;

  // step divider
  logic [DVD_W-1:0]      dvd_r;
  logic [DSOR_W-1:0]     drem_r;
  logic [DSOR_W-1:0]     dsor_r;
  logic [PHASE_BITS-1:0] quo_r;
  logic [CNT_W-1:0]      cnt_r;

  // lookup and fade
  logic [MAG_W-1:0]    rom_q_r;
  logic                full_r;
  logic                neg_r;
  logic                fin_r;
  logic                fade_in_r;
  logic [LEN_W-1:0]    tw20_r;
  logic [LEN_W-1:0]    rem_t_r;
  logic [MAG_W-1:0]    mag_r;
  logic [LEN_W-1:0]    gain_r;
  logic [PROD_W-1:0]   prod_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_playing_r;

  logic in_ready;
  logic accept;
  logic emit;
  logic cnt_last;

  logic [IDX_W-1:0]    tab_i;
  logic [IDX_W-1:0]    rom_addr;
  logic [LEN_W-1:0]    t_low;
  logic [GAIN20_W-1:0] tw20;
  logic [GAIN20_W-1:0] rw20;
  logic                fade_out;
  logic [MAG_W-1:0]    mag_sel;
  logic [DSOR_W:0]     dtrial;
  logic                dge;
  logic [LEN_W:0]      ftrial;
  logic                fge;
  logic [SAMPLE_W-1:0] mag_ext;

  // reload the count for the divide when the multiply ends
  function automatic logic [CNT_W-1:0] last_mul_cnt(input logic [CNT_W-1:0] c);
    return (c == CNT_W'(1)) ? CNT_W'(MAG_W) : (c - CNT_W'(1));
  endfunction

  assign accept   = in_ch.valid && in_ready;
  assign cnt_last = (cnt_r == CNT_W'(1));

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.sample  = out_sample_r;
  assign out_ch.playing = out_playing_r;

  // quarter-wave addressing; odd quadrants mirror, index zero mirrors to full scale
  assign tab_i    = ph_r[PHASE_BITS-3 -: IDX_W];
  assign rom_addr = ph_r[PHASE_BITS-2] ? (~tab_i + IDX_W'(1)) : tab_i;

  // 20*t and 20*(L-t), valid only while t <= L
  assign t_low = t_r[LEN_W-1:0];
  assign tw20  = GAIN20_W'({t_low, 4'b0}) + GAIN20_W'({t_low, 2'b0});
  assign rw20  = GAIN20_W'({rem_t_r, 4'b0}) + GAIN20_W'({rem_t_r, 2'b0});
  assign fade_out = rw20 < GAIN20_W'(len_r);
  assign mag_sel  = full_r ? FULL_SCALE : rom_q_r;

  assign dtrial = {drem_r, dvd_r[DVD_W-1]} - {1'b0, dsor_r};
  assign dge    = !dtrial[DSOR_W];
  assign ftrial = prod_r[PROD_W-1:MAG_W-1] - {1'b0, len_r};
  assign fge    = !ftrial[LEN_W];

  assign mag_ext = {1'b0, prod_r[MAG_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = (in_ch.start_req && rate_r != '0) ? ST_DIV : ST_LOOKUP;
        end
      end
      ST_DIV: begin
        if (cnt_last) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        state_nxt = (!fin_r && (fade_in_r || fade_out)) ? ST_MUL : ST_EMIT;
      end
      ST_MUL: begin
        if (cnt_last) state_nxt = ST_FDIV;
      end
      ST_FDIV: begin
        if (cnt_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // note state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
      step_r <= '0;
      ph_r   <= '0;
      t_r    <= '0;
      len_r  <= '0;
    end else begin
      if (cfg_we) begin
        rate_r <= cfg_wdata;
      end
      if (accept && in_ch.start_req) begin
        len_r <= in_ch.note_length;
        t_r   <= '0;
        ph_r  <= '0;
        if (rate_r == '0) begin
          step_r <= '0;
        end
      end
      if (state_r == ST_DIV && cnt_last) begin
        step_r <= {quo_r[PHASE_BITS-2:0], dge};
      end
      if (emit && !fin_r) begin
        t_r  <= t_r + T_W'(1);
        ph_r <= ph_r + step_r;
      end
    end
  end

  // datapath: step divider, table read, serial multiply and divide
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        dvd_r  <= {in_ch.frequency, {PHASE_BITS{1'b0}}};
        dsor_r <= {rate_r, 4'b0};
        drem_r <= '0;
        cnt_r  <= CNT_W'(DVD_W);
      end
      ST_DIV: begin
        drem_r <= dge ? dtrial[DSOR_W-1:0] : {drem_r[DSOR_W-2:0], dvd_r[DVD_W-1]};
        quo_r  <= {quo_r[PHASE_BITS-2:0], dge};
        dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
        cnt_r  <= cnt_r - CNT_W'(1);
      end
      ST_LOOKUP: begin
        rom_q_r   <= SINE_ROM[rom_addr];
        full_r    <= ph_r[PHASE_BITS-2] && (tab_i == '0);
        neg_r     <= ph_r[PHASE_BITS-1];
        fin_r     <= t_r > T_W'(len_r);
        fade_in_r <= tw20 < GAIN20_W'(len_r);
        tw20_r    <= tw20[LEN_W-1:0];
        rem_t_r   <= len_r - t_low;
      end
      ST_PREP: begin
        mag_r  <= mag_sel;
        gain_r <= fade_in_r ? tw20_r : rw20[LEN_W-1:0];
        cnt_r  <= CNT_W'(MAG_W);
        if (fin_r || fade_in_r || fade_out) begin
          prod_r <= '0;
        end else begin
          prod_r <= PROD_W'(mag_sel);
        end
      end
      ST_MUL: begin
        prod_r <= {prod_r[PROD_W-2:0], 1'b0} + (mag_r[MAG_W-1] ? PROD_W'(gain_r) : '0);
        mag_r  <= {mag_r[MAG_W-2:0], 1'b0};
        cnt_r  <= last_mul_cnt(cnt_r);
      end
      ST_FDIV: begin
        // remainder sits above the dividend bits still to be shifted in
        prod_r <= {(fge ? ftrial[LEN_W-1:0] : prod_r[PROD_W-2:MAG_W-1]),
                   prod_r[MAG_W-2:0], fge};
        cnt_r  <= cnt_r - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sample_r  <= neg_r ? $signed(~mag_ext + SAMPLE_W'(1)) : $signed(mag_ext);
      out_playing_r <= t_r < T_W'(len_r);
    end
  end

`ifndef SYNTHESIS
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.start_req |=> t_r == '0 && ph_r == '0)
    else $error("start request did not clear index and phase");

  a_step_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> drem_r < dsor_r)
    else $error("step divider remainder not below divisor");

  a_fade_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FDIV |-> prod_r[PROD_W-1:MAG_W] < len_r)
    else $error("fade divider remainder not below note length");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    t_r <= T_W'(len_r) + T_W'(1))
    else $error("sample index ran past note end");
`endif

endmodule
